// File: rtl/core/svs_pkg.sv
package svs_pkg;

   // Field and datapath widths
   localparam int VALUE_WIDTH     = 28;
   localparam int MAG_WIDTH       = 24;
   localparam int VAL_WIDTH       = 14;
   localparam int Q10_WIDTH       = 10;
   localparam int Q100_WIDTH      = 7;
   localparam int DIGIT_WIDTH     = 4;
   localparam int POS_WIDTH       = 3;
   localparam int SEG_WIDTH       = 8;
   localparam int GLYPH_WIDTH     = 8;
   localparam int DEC_WIDTH       = 3;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 3;

   // Number of display positions, scanned 1..DIGITS
   localparam int DIGITS = 4;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Saturation of the magnitude in thousandths
   localparam logic [VALUE_WIDTH-1:0] SAT_LIMIT   = 28'd9999000;
   localparam logic [MAG_WIDTH-1:0]   MAG_NEG_SAT = 24'd9999000;
   localparam logic [MAG_WIDTH-1:0]   MAG_POS_SAT = 24'd9998000;

   // Magnitude band thresholds
   localparam logic [MAG_WIDTH-1:0] THR_ONE      = 24'd1000;
   localparam logic [MAG_WIDTH-1:0] THR_TEN      = 24'd10000;
   localparam logic [MAG_WIDTH-1:0] THR_HUNDRED  = 24'd100000;
   localparam logic [MAG_WIDTH-1:0] THR_THOUSAND = 24'd1000000;

   // Reciprocals ceil(2^34 / d): exact quotient for any magnitude below 2^34 / 1000
   localparam int RECIP_WIDTH = 31;
   localparam int RECIP_SHIFT = 34;
   localparam int PROD_WIDTH  = MAG_WIDTH + RECIP_WIDTH;
   localparam logic [RECIP_WIDTH-1:0] RECIP_10   = 31'd1717986919;
   localparam logic [RECIP_WIDTH-1:0] RECIP_100  = 31'd171798692;
   localparam logic [RECIP_WIDTH-1:0] RECIP_1000 = 31'd17179870;

   // Divide by ten: (x * 6554) >> 16 exact for x < 16384
   localparam int WIDE_DIV10_MAGIC = 6554;
   localparam int WIDE_DIV10_SHIFT = 16;
   // Divide by ten: (x * 205) >> 11 exact for x < 1029
   localparam int NARROW_DIV10_MAGIC = 205;
   localparam int NARROW_DIV10_SHIFT = 11;

   // Glyph codes and segment bits
   localparam logic [GLYPH_WIDTH-1:0] GLYPH_BLANK = 8'h0b;
   localparam logic [GLYPH_WIDTH-1:0] GLYPH_MINUS = 8'hfb;
   localparam logic [GLYPH_WIDTH-1:0] GLYPH_NONE  = 8'hff;
   localparam logic [SEG_WIDTH-1:0]   SEG_DOT     = 8'h80;
   localparam logic [SEG_WIDTH-1:0]   SEG_MINUS   = 8'h40;

   localparam logic [SEG_WIDTH-1:0] SEG_TABLE [16] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
      8'h7f, 8'h6f, 8'h77, 8'h00, 8'h39, 8'h5e, 8'h79, 8'h71
   };

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_DECIMALS          = 1'b0,
      CSR_LOW_RANGE_DEEPNEG = 1'b1
   } csr_index_type;

   // Magnitude bands
   typedef enum logic [2:0] {
      BAND_ONE      = 3'd0,
      BAND_TEN      = 3'd1,
      BAND_HUNDRED  = 3'd2,
      BAND_THOUSAND = 3'd3,
      BAND_OVER     = 3'd4
   } band_type;

   // Divisor applied to the magnitude (1000 / scale)
   typedef enum logic [1:0] {
      DIV_1    = 2'd0,
      DIV_10   = 2'd1,
      DIV_100  = 2'd2,
      DIV_1000 = 2'd3
   } div_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0] dot;
      logic [POS_WIDTH-1:0] count;
      div_type              div;
   } fmt_type;

   // Per-item control carried down the back pipeline
   typedef struct packed {
      logic                 neg;
      logic [POS_WIDTH-1:0] pos;
      fmt_type              fmt;
   } tag_type;

   typedef struct packed {
      tag_type              tag;
      logic [MAG_WIDTH-1:0] mag;
   } queue_entry_type;

endpackage

// File: rtl/core/seven_segment_value_scanner.sv
// Throughput: one item per cycle unless rsp_ready stalls; the front classifies in the
// accepting cycle and the back runs three arithmetic stages (divide, tens split,
// hundreds split) plus the output register, so a stalled rsp_ side backs up the queue
// before req_ready drops.
// Reset (synchronous): queue and pipeline empty, decimals 0, deep-negative flag 0,
// scan position 1.
module seven_segment_value_scanner #(
   parameter int QUEUE_DEPTH = svs_pkg::QUEUE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [svs_pkg::VALUE_WIDTH-1:0] req_value_milli,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [svs_pkg::POS_WIDTH-1:0]          rsp_digit_select,
   output logic [svs_pkg::SEG_WIDTH-1:0]          rsp_segments,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [svs_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [svs_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import svs_pkg::*;

   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_data;
   logic            pop_valid;
   logic            pop_ready;
   queue_entry_type pop_data;

   // Front: accept, saturate, classify, assign scan position
   svs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value_milli (req_value_milli),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   // Decoupling queue
   svs_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back: scale, digit split, segment encode
   svs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments)
   );

endmodule

// File: rtl/core/svs_front.sv
module svs_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [svs_pkg::VALUE_WIDTH-1:0] req_value_milli,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [svs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [svs_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output svs_pkg::queue_entry_type             push_data
);
   import svs_pkg::*;

   logic [DEC_WIDTH-1:0] decimals_ff, decimals_in;
   logic                 low_range_ff, low_range_in;
   logic [POS_WIDTH-1:0] scan_ff, scan_in;

   logic                   accept;
   logic [VALUE_WIDTH-1:0] raw;
   logic                   neg;
   logic [VALUE_WIDTH-1:0] mag_full;
   logic [MAG_WIDTH-1:0]   mag;
   logic [DEC_WIDTH-1:0]   dec_eff;
   band_type               band;
   logic [POS_WIDTH-1:0]   pos;

   function automatic fmt_type mk_fmt(logic [POS_WIDTH-1:0] dot,
                                      logic [POS_WIDTH-1:0] count, div_type div);
      fmt_type f;
      f.dot   = dot;
      f.count = count;
      f.div   = div;
      return f;
   endfunction

   // Scale, dot position and digit count by sign, band and decimals
   function automatic fmt_type fmt_lookup(logic is_neg, band_type b, logic [1:0] dec);
      fmt_type f;
      f = mk_fmt(3'd4, 3'd4, DIV_1000);
      unique case (b)
         BAND_ONE, BAND_TEN: begin
            unique case (dec)
               2'd0: f = mk_fmt(3'd4, 3'd1, DIV_1000);
               2'd1: f = mk_fmt(3'd3, 3'd2, DIV_100);
               2'd2: f = mk_fmt(3'd2, 3'd3, DIV_10);
               2'd3: f = is_neg ? mk_fmt(3'd2, 3'd3, DIV_10) : mk_fmt(3'd1, 3'd4, DIV_1);
            endcase
         end
         BAND_HUNDRED: begin
            unique case (dec)
               2'd0: f = is_neg ? mk_fmt(3'd4, 3'd3, DIV_1000) : mk_fmt(3'd4, 3'd2, DIV_1000);
               2'd1: f = is_neg ? mk_fmt(3'd3, 3'd4, DIV_100) : mk_fmt(3'd3, 3'd3, DIV_100);
               2'd2, 2'd3: f = is_neg ? mk_fmt(3'd3, 3'd3, DIV_100) : mk_fmt(3'd2, 3'd4, DIV_10);
            endcase
         end
         BAND_THOUSAND: begin
            if (is_neg || dec == 2'd0) begin
               f = mk_fmt(3'd4, 3'd3, DIV_1000);
            end else begin
               f = mk_fmt(3'd3, 3'd4, DIV_100);
            end
         end
         BAND_OVER: f = mk_fmt(3'd4, 3'd4, DIV_1000);
         default:   f = mk_fmt(3'd4, 3'd4, DIV_1000);
      endcase
      return f;
   endfunction

   // Handshakes: the queue decides when an item can enter
   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign csr_ready  = 1'b1;

   // Magnitude with saturation
   assign raw      = req_value_milli;
   assign neg      = raw[VALUE_WIDTH-1];
   assign mag_full = neg ? VALUE_WIDTH'(~raw + 1'b1) : raw;
   assign mag      = (mag_full > SAT_LIMIT) ? (neg ? MAG_NEG_SAT : MAG_POS_SAT)
                                            : mag_full[MAG_WIDTH-1:0];

   // Effective decimal count
   always_comb begin
      dec_eff = decimals_ff;
      if (low_range_ff && decimals_ff != '0) begin
         dec_eff = DEC_WIDTH'(1);
      end
      if (dec_eff > DEC_WIDTH'(3)) begin
         dec_eff = DEC_WIDTH'(1);
      end
   end

   // Band classification, negative side closes the hundred band inclusively
   always_comb begin
      priority if (mag <= THR_ONE) begin
         band = BAND_ONE;
      end else if (mag < THR_TEN) begin
         band = BAND_TEN;
      end else if (neg ? (mag <= THR_HUNDRED) : (mag < THR_HUNDRED)) begin
         band = BAND_HUNDRED;
      end else if (mag < THR_THOUSAND) begin
         band = BAND_THOUSAND;
      end else begin
         band = BAND_OVER;
      end
   end

   // Scan position for this item
   assign pos = (scan_ff == '0 || scan_ff > POS_WIDTH'(DIGITS)) ? POS_WIDTH'(1) : scan_ff;
   assign scan_in = !accept ? scan_ff
                  : (pos >= POS_WIDTH'(DIGITS)) ? POS_WIDTH'(1) : pos + 1'b1;

   // Queue entry
   always_comb begin
      push_data.tag.neg = neg;
      push_data.tag.pos = pos;
      push_data.tag.fmt = fmt_lookup(neg, band, dec_eff[1:0]);
      push_data.mag     = mag;
   end

   // Configuration writes
   always_comb begin
      decimals_in  = decimals_ff;
      low_range_in = low_range_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DECIMALS:          decimals_in  = csr_data;
            CSR_LOW_RANGE_DEEPNEG: low_range_in = csr_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decimals_ff  <= '0;
         low_range_ff <= 1'b0;
         scan_ff      <= POS_WIDTH'(1);
      end else begin
         decimals_ff  <= decimals_in;
         low_range_ff <= low_range_in;
         scan_ff      <= scan_in;
      end
   end

   // Scan walks 1..DIGITS, advances on every transfer and wraps after DIGITS
   assert property (@(posedge clock) disable iff (reset)
      accept |=> scan_ff == (($past(pos) == POS_WIDTH'(DIGITS)) ? POS_WIDTH'(1)
                                                              : $past(pos) + 1'b1))
      else $error("scan position did not advance");

endmodule

// File: rtl/core/svs_queue.sv
module svs_queue #(
   parameter int QUEUE_DEPTH = svs_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  svs_pkg::queue_entry_type push_data,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output svs_pkg::queue_entry_type pop_data
);
   import svs_pkg::*;

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type      entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 push;
   logic                 pop;

   assign push_ready = count_ff != CNT_WIDTH'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue push lost");

endmodule

// File: rtl/core/svs_back.sv
module svs_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  svs_pkg::queue_entry_type        pop_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [svs_pkg::POS_WIDTH-1:0]   rsp_digit_select,
   output logic [svs_pkg::SEG_WIDTH-1:0]   rsp_segments
);
   import svs_pkg::*;

   localparam int W_PROD_WIDTH = VAL_WIDTH + 13;
   localparam int N_PROD_WIDTH = Q10_WIDTH + 8;
   localparam int D_PROD_WIDTH = Q100_WIDTH + 8;

   // Pipeline advance: everything moves unless a result sits untaken
   logic adv;

   logic                   s1_valid_ff;
   tag_type                s1_tag_ff;
   logic [VAL_WIDTH-1:0]   s1_val_ff, s1_val_in;
   logic [RECIP_WIDTH-1:0] recip;
   logic [PROD_WIDTH-1:0]  quot_prod;

   logic                     s2_valid_ff;
   tag_type                  s2_tag_ff;
   logic [Q10_WIDTH-1:0]     s2_q10_ff, s2_q10_in;
   logic [DIGIT_WIDTH-1:0]   s2_d3_ff, s2_d3_in;
   logic [W_PROD_WIDTH-1:0]  q10_prod;
   logic [VAL_WIDTH-1:0]     q10_times10;
   logic [VAL_WIDTH-1:0]     d3_full;

   logic                     s3_valid_ff;
   tag_type                  s3_tag_ff;
   logic [Q10_WIDTH-1:0]     s3_q10_ff;
   logic [Q100_WIDTH-1:0]    s3_q100_ff, s3_q100_in;
   logic [DIGIT_WIDTH-1:0]   s3_d2_ff, s3_d2_in;
   logic [DIGIT_WIDTH-1:0]   s3_d3_ff;
   logic [N_PROD_WIDTH-1:0]  q100_prod;
   logic [Q10_WIDTH-1:0]     q100_times10;
   logic [Q10_WIDTH-1:0]     d2_full;

   logic [D_PROD_WIDTH-1:0]  d0_prod;
   logic [DIGIT_WIDTH-1:0]   d0;
   logic [DIGIT_WIDTH-1:0]   d1;
   logic [Q100_WIDTH-1:0]    d0_times10;
   logic [Q100_WIDTH-1:0]    d1_full;
   logic [1:0]               slot;
   logic [GLYPH_WIDTH-1:0]   glyph;
   logic                     glyph_digit;
   logic [SEG_WIDTH-1:0]     glyph_seg;
   logic [POS_WIDTH:0]       reach;
   logic [SEG_WIDTH-1:0]     seg;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [POS_WIDTH-1:0]   rsp_digit_select_ff;
   logic [SEG_WIDTH-1:0]   rsp_segments_ff;

   function automatic logic [GLYPH_WIDTH-1:0] digit_glyph(logic [Q10_WIDTH-1:0] value);
      return (value > Q10_WIDTH'(15)) ? GLYPH_NONE : {4'b0, value[3:0]};
   endfunction

   function automatic logic [SEG_WIDTH-1:0] glyph_segments(logic [GLYPH_WIDTH-1:0] g);
      logic [SEG_WIDTH-1:0] s;
      if (g[7:4] == 4'd0) begin
         s = SEG_TABLE[g[3:0]];
      end else if (g == GLYPH_MINUS) begin
         s = SEG_MINUS;
      end else begin
         s = '0;
      end
      return s;
   endfunction

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;

   // Stage 1: scaled value = magnitude / divisor by reciprocal multiply
   always_comb begin
      unique case (pop_data.tag.fmt.div)
         DIV_1:    recip = '0;
         DIV_10:   recip = RECIP_10;
         DIV_100:  recip = RECIP_100;
         DIV_1000: recip = RECIP_1000;
      endcase
   end
   assign quot_prod = {{RECIP_WIDTH{1'b0}}, pop_data.mag} * {{MAG_WIDTH{1'b0}}, recip};
   // Scaled value never exceeds 9999 for any reachable format
   assign s1_val_in = (pop_data.tag.fmt.div == DIV_1) ? pop_data.mag[VAL_WIDTH-1:0]
                                                     : quot_prod[RECIP_SHIFT +: VAL_WIDTH];

   // Stage 2: split off the last digit
   assign q10_prod    = W_PROD_WIDTH'(s1_val_ff) * W_PROD_WIDTH'(WIDE_DIV10_MAGIC);
   assign s2_q10_in   = q10_prod[WIDE_DIV10_SHIFT +: Q10_WIDTH];
   assign q10_times10 = VAL_WIDTH'({s2_q10_in, 3'b0}) + VAL_WIDTH'({s2_q10_in, 1'b0});
   assign d3_full     = s1_val_ff - q10_times10;
   assign s2_d3_in    = d3_full[DIGIT_WIDTH-1:0];

   // Stage 3: split off the tens digit
   assign q100_prod    = N_PROD_WIDTH'(s2_q10_ff) * N_PROD_WIDTH'(NARROW_DIV10_MAGIC);
   assign s3_q100_in   = q100_prod[NARROW_DIV10_SHIFT +: Q100_WIDTH];
   assign q100_times10 = Q10_WIDTH'({s3_q100_in, 3'b0}) + Q10_WIDTH'({s3_q100_in, 1'b0});
   assign d2_full      = s2_q10_ff - q100_times10;
   assign s3_d2_in     = d2_full[DIGIT_WIDTH-1:0];

   // Output stage: leading digits
   assign d0_prod    = D_PROD_WIDTH'(s3_q100_ff) * D_PROD_WIDTH'(NARROW_DIV10_MAGIC);
   assign d0         = d0_prod[NARROW_DIV10_SHIFT +: DIGIT_WIDTH];
   assign d0_times10 = Q100_WIDTH'({d0, 3'b0}) + Q100_WIDTH'({d0, 1'b0});
   assign d1_full    = s3_q100_ff - d0_times10;
   assign d1         = d1_full[DIGIT_WIDTH-1:0];

   // Glyph of the scanned position, blank padded to the digit count
   assign slot = 2'(s3_tag_ff.pos - 1'b1);
   always_comb begin
      glyph = GLYPH_BLANK;
      unique case (s3_tag_ff.fmt.count)
         3'd4: begin
            unique case (slot)
               2'd0: glyph = {4'b0, d0};
               2'd1: glyph = {4'b0, d1};
               2'd2: glyph = {4'b0, s3_d2_ff};
               2'd3: glyph = {4'b0, s3_d3_ff};
            endcase
         end
         3'd3: begin
            unique case (slot)
               2'd0: glyph = GLYPH_BLANK;
               2'd1: glyph = digit_glyph(Q10_WIDTH'(s3_q100_ff));
               2'd2: glyph = {4'b0, s3_d2_ff};
               2'd3: glyph = {4'b0, s3_d3_ff};
            endcase
         end
         3'd2: begin
            unique case (slot)
               2'd0: glyph = GLYPH_BLANK;
               2'd1: glyph = s3_tag_ff.neg ? GLYPH_MINUS : GLYPH_BLANK;
               2'd2: glyph = digit_glyph(s3_q10_ff);
               2'd3: glyph = {4'b0, s3_d3_ff};
            endcase
         end
         default: begin
            glyph = (slot == 2'd3) ? {4'b0, s3_d3_ff} : GLYPH_BLANK;
         end
      endcase
   end

   // Segment pattern with minus and dot
   assign glyph_digit = glyph[7:4] == 4'd0;
   assign glyph_seg   = glyph_segments(glyph);
   assign reach       = {1'b0, s3_tag_ff.fmt.count} + {1'b0, s3_tag_ff.pos};
   always_comb begin
      priority if (!s3_tag_ff.neg) begin
         seg = glyph_seg;
      end else if (reach >= (POS_WIDTH + 1)'(DIGITS)) begin
         seg = glyph_seg;
         if (glyph_digit && s3_tag_ff.pos == POS_WIDTH'(1)) begin
            seg = seg | SEG_MINUS;
         end
      end else begin
         seg = glyph_digit ? glyph_seg : '0;
      end
      if (s3_tag_ff.fmt.dot == s3_tag_ff.pos) begin
         seg = seg | SEG_DOT;
      end
   end

   assign rsp_valid_in = adv ? s3_valid_ff : rsp_valid_ff;

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= pop_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff           <= pop_data.tag;
         s1_val_ff           <= s1_val_in;
         s2_tag_ff           <= s1_tag_ff;
         s2_q10_ff           <= s2_q10_in;
         s2_d3_ff            <= s2_d3_in;
         s3_tag_ff           <= s2_tag_ff;
         s3_q10_ff           <= s2_q10_ff;
         s3_q100_ff          <= s3_q100_in;
         s3_d2_ff            <= s3_d2_in;
         s3_d3_ff            <= s2_d3_ff;
         rsp_digit_select_ff <= s3_tag_ff.pos;
         rsp_segments_ff     <= seg;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digit_select = rsp_digit_select_ff;
   assign rsp_segments     = rsp_segments_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_digit_select_ff >= POS_WIDTH'(1) &&
                       rsp_digit_select_ff <= POS_WIDTH'(DIGITS))
      else $error("digit select out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(s3_valid_ff) && $stable(s1_valid_ff))
      else $error("pipeline moved under a stalled result");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import svs_pkg::*;

   // Digit layout: dot position, digit count, divisor applied to the magnitude
   typedef struct packed {
      logic [2:0]  dot;
      logic [2:0]  count;
      logic [10:0] divisor;
   } digit_layout_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] reading;
      logic [POS_WIDTH-1:0]   digit;
      logic [SEG_WIDTH-1:0]   segs;
   } scan_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [VALUE_WIDTH-1:0] req_value_milli = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [POS_WIDTH-1:0]          rsp_digit_select;
   logic [SEG_WIDTH-1:0]          rsp_segments;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]     csr_data = '0;

   // Stimulus control
   logic burst_mode = 1'b0;
   logic rsp_hold   = 1'b0;

   // Predictor state, mirrors the block after reset
   logic [DEC_WIDTH-1:0] cfg_decimals      = '0;
   logic                 cfg_deep_negative = 1'b0;
   logic [POS_WIDTH-1:0] scan_position     = 3'd1;

   logic [VALUE_WIDTH-1:0] pending_readings [$];
   scan_result_type        expected_scans [$];
   scan_result_type        predicted_scan;
   scan_result_type        oldest_scan;
   int                     accepted_count = 0;
   int                     mismatch_count = 0;

   seven_segment_value_scanner u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value_milli  (req_value_milli),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digit_select (rsp_digit_select),
      .rsp_segments     (rsp_segments),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic digit_layout_type make_layout(input int dot, input int count,
                                                    input int divisor);
      digit_layout_type lay;
      lay.dot     = 3'(dot);
      lay.count   = 3'(count);
      lay.divisor = 11'(divisor);
      return lay;
   endfunction

   // Common-cathode glyphs 0..F; blank code falls on the empty entry
   function automatic logic [SEG_WIDTH-1:0] glyph_to_segments(input logic [GLYPH_WIDTH-1:0] g);
      case (g)
         8'h00: return 8'h3f;
         8'h01: return 8'h06;
         8'h02: return 8'h5b;
         8'h03: return 8'h4f;
         8'h04: return 8'h66;
         8'h05: return 8'h6d;
         8'h06: return 8'h7d;
         8'h07: return 8'h07;
         8'h08: return 8'h7f;
         8'h09: return 8'h6f;
         8'h0a: return 8'h77;
         8'h0b: return 8'h00;
         8'h0c: return 8'h39;
         8'h0d: return 8'h5e;
         8'h0e: return 8'h79;
         8'h0f: return 8'h71;
         GLYPH_MINUS: return SEG_MINUS;
         default: return 8'h00;
      endcase
   endfunction

   // Segment pattern driven for one reading at the given scan position
   function automatic scan_result_type scan_digit_pattern(
         input logic [VALUE_WIDTH-1:0] reading,
         input logic [DEC_WIDTH-1:0] dec_req,
         input logic deep_neg,
         input logic [POS_WIDTH-1:0] position);
      logic                             neg;
      logic [VALUE_WIDTH-1:0]           mag;
      logic [DEC_WIDTH-1:0]             dec;
      band_type                         band;
      digit_layout_type                 lay;
      int unsigned                      val;
      int unsigned                      pos;
      logic [3:0][GLYPH_WIDTH-1:0]      glyphs;
      logic [GLYPH_WIDTH-1:0]           g;
      logic [SEG_WIDTH-1:0]             seg;
      scan_result_type                  res;

      // Magnitude with saturation
      neg = reading[VALUE_WIDTH-1];
      mag = neg ? -reading : reading;
      if (mag > 28'd9999000) mag = neg ? 28'd9999000 : 28'd9998000;

      // Effective decimals
      dec = (deep_neg && dec_req != 0) ? 3'd1 : dec_req;
      if (dec > 3) dec = 3'd1;

      // Band; the hundreds threshold is inclusive for negatives
      if (mag <= 1000) band = BAND_ONE;
      else if (mag < 10000) band = BAND_TEN;
      else if (neg ? (mag <= 100000) : (mag < 100000)) band = BAND_HUNDRED;
      else if (mag < 1000000) band = BAND_THOUSAND;
      else band = BAND_OVER;

      // Layout table
      if (!neg) begin
         case (band)
            BAND_ONE, BAND_TEN: begin
               case (dec)
                  3'd0: lay = make_layout(4, 1, 1000);
                  3'd1: lay = make_layout(3, 2, 100);
                  3'd2: lay = make_layout(2, 3, 10);
                  default: lay = make_layout(1, 4, 1);
               endcase
            end
            BAND_HUNDRED: begin
               if (dec == 0) lay = make_layout(4, 2, 1000);
               else if (dec == 1) lay = make_layout(3, 3, 100);
               else lay = make_layout(2, 4, 10);
            end
            BAND_THOUSAND: begin
               if (dec == 0) lay = make_layout(4, 3, 1000);
               else lay = make_layout(3, 4, 100);
            end
            default: lay = make_layout(4, 4, 1000);
         endcase
      end else begin
         case (band)
            BAND_ONE, BAND_TEN: begin
               if (dec == 0) lay = make_layout(4, 1, 1000);
               else if (dec == 1) lay = make_layout(3, 2, 100);
               else lay = make_layout(2, 3, 10);
            end
            BAND_HUNDRED: begin
               if (dec == 0) lay = make_layout(4, 3, 1000);
               else if (dec == 1) lay = make_layout(3, 4, 100);
               else lay = make_layout(3, 3, 100);
            end
            BAND_THOUSAND: lay = make_layout(4, 3, 1000);
            default: lay = make_layout(4, 4, 1000);
         endcase
      end

      // Blank-padded digit split
      val = 32'(mag / lay.divisor);
      case (lay.count)
         3'd4: begin
            glyphs[0] = GLYPH_WIDTH'(val / 1000);
            glyphs[1] = GLYPH_WIDTH'(val % 1000 / 100);
            glyphs[2] = GLYPH_WIDTH'(val % 100 / 10);
            glyphs[3] = GLYPH_WIDTH'(val % 10);
         end
         3'd3: begin
            glyphs[0] = GLYPH_BLANK;
            glyphs[1] = GLYPH_WIDTH'(val / 100);
            glyphs[2] = GLYPH_WIDTH'(val % 100 / 10);
            glyphs[3] = GLYPH_WIDTH'(val % 10);
         end
         3'd2: begin
            glyphs[0] = GLYPH_BLANK;
            glyphs[1] = neg ? GLYPH_MINUS : GLYPH_BLANK;
            glyphs[2] = GLYPH_WIDTH'(val / 10);
            glyphs[3] = GLYPH_WIDTH'(val % 10);
         end
         default: begin
            glyphs[0] = GLYPH_BLANK;
            glyphs[1] = GLYPH_BLANK;
            glyphs[2] = GLYPH_BLANK;
            glyphs[3] = GLYPH_WIDTH'(val % 10);
         end
      endcase

      // Segments at the scan position, minus and dot overlay
      pos = 32'(position);
      if (pos < 1 || pos > DIGITS) pos = 1;
      g = glyphs[pos-1];
      if (!neg) begin
         seg = glyph_to_segments(g);
      end else if (lay.count + pos >= 4) begin
         seg = glyph_to_segments(g);
         if (g <= 8'h0f && pos == 1) seg = seg | SEG_MINUS;
      end else begin
         seg = (g <= 8'h0f) ? glyph_to_segments(g) : 8'h00;
      end
      if (lay.dot == pos) seg = seg | SEG_DOT;

      res.reading = reading;
      res.digit   = POS_WIDTH'(pos);
      res.segs    = seg;
      return res;
   endfunction

   // Readings spread over the bands, their edges and the saturation points
   function automatic logic [VALUE_WIDTH-1:0] random_reading();
      int unsigned            m;
      logic [VALUE_WIDTH-1:0] r;
      case ($urandom_range(0, 9))
         0: m = $urandom_range(0, 1000);
         1: m = $urandom_range(1001, 9999);
         2: m = $urandom_range(10000, 99999);
         3: m = $urandom_range(100000, 999999);
         4: m = $urandom_range(1000000, 9999999);
         5: begin
            case ($urandom_range(0, 4))
               0: m = 1000;
               1: m = 10000;
               2: m = 100000;
               3: m = 1000000;
               default: m = 9999000;
            endcase
            m = m + $urandom_range(0, 4) - 2;
         end
         6: m = $urandom_range(9997000, 10001000);
         7: m = $urandom_range(0, 99999999);
         default: m = $urandom;
      endcase
      r = VALUE_WIDTH'(m);
      return ($urandom_range(0, 1) != 0) ? -r : r;
   endfunction

   // Configuration write; the model copy is updated at the transfer
   task automatic csr_write(input csr_index_type index, input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_DECIMALS) cfg_decimals = data;
      else cfg_deep_negative = data[0];
   endtask

   // Wait for every queued reading to transfer and every result to return
   task automatic settle_idle();
      int waited;
      waited = 0;
      while ((pending_readings.size() != 0 || req_valid || expected_scans.size() != 0)
             && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
   endtask

   // Request driver: predict on each transfer, then offer the next reading
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_scan = scan_digit_pattern(req_value_milli, cfg_decimals,
                                                cfg_deep_negative, scan_position);
            expected_scans.push_back(predicted_scan);
            scan_position = (predicted_scan.digit >= DIGITS) ? 3'd1 : predicted_scan.digit + 3'd1;
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (pending_readings.size() != 0 && (burst_mode || $urandom_range(0, 99) >= 10)) begin
               req_valid       <= 1'b1;
               req_value_milli <= pending_readings.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: compare each transfer against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_scans.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: digit %0d segments %02h",
                           rsp_digit_select, rsp_segments);
            end else begin
               oldest_scan = expected_scans.pop_front();
               if (rsp_digit_select !== oldest_scan.digit || rsp_segments !== oldest_scan.segs)
               begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch on reading %0d: expected %0d/%02h, got %0d/%02h",
                              $signed(oldest_scan.reading), oldest_scan.digit, oldest_scan.segs,
                              rsp_digit_select, rsp_segments);
               end
            end
         end
         rsp_ready <= !rsp_hold && (burst_mode || $urandom_range(0, 99) >= 10);
      end
   end

   // Long receiver hold-off while the sender keeps offering
   initial begin
      wait (accepted_count >= 150);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (80) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int directed [20];
      int phase;
      logic [DEC_WIDTH-1:0] dec_val;
      logic                 deep_val;

      directed = '{0, 1, 1000, 1001, 9999, 10000, 99999, 100000, 999999, 1000000,
                   9999000, 9999001, 99999999, 134217727, -1, -1000, -100000,
                   -100001, -9999001, -134217728};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: band edges, saturation and field extremes at reset settings
      @(negedge clock);
      foreach (directed[i]) pending_readings.push_back(VALUE_WIDTH'(directed[i]));
      settle_idle();

      // Directed: three-digit negative reaching 1000, at every scan position
      csr_write(CSR_DECIMALS, 3'd2);
      @(negedge clock);
      repeat (4) pending_readings.push_back(-28'sd100000);
      pending_readings.push_back(-28'sd5);
      pending_readings.push_back(28'sd5);
      settle_idle();

      // Random phases, each under its own settings
      for (phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin dec_val = 3'd7; deep_val = 1'b0; end
            1: begin dec_val = 3'd7; deep_val = 1'b1; end
            2: begin dec_val = 3'd0; deep_val = 1'b1; end
            3: begin dec_val = 3'd3; deep_val = 1'b0; end
            4: begin dec_val = 3'd3; deep_val = 1'b1; end
            default: begin
               dec_val  = DEC_WIDTH'($urandom_range(0, 7));
               deep_val = 1'($urandom_range(0, 1));
            end
         endcase
         csr_write(CSR_DECIMALS, dec_val);
         csr_write(CSR_LOW_RANGE_DEEPNEG, {2'($urandom_range(0, 3)), deep_val});
         if (phase == 3) burst_mode <= 1'b1;
         @(negedge clock);
         repeat (50) pending_readings.push_back(random_reading());
         settle_idle();
         if (phase == 3) burst_mode <= 1'b0;
      end

      if (mismatch_count == 0 && expected_scans.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
